### hdl/mqpp_pkg.sv
// Shared types and codes for the MQTT PUBLISH packet parser.
package mqpp_pkg;

	localparam int unsigned MaxLenBytes = 4;

	typedef enum logic [3:0] {
		PH_HDR   = 4'd0,
		PH_LEN   = 4'd1,
		PH_TLH   = 4'd2,
		PH_TLL   = 4'd3,
		PH_TOPIC = 4'd4,
		PH_IDH   = 4'd5,
		PH_IDL   = 4'd6,
		PH_PAY   = 4'd7,
		PH_DONE  = 4'd8,
		PH_ERR   = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		K_HDR   = 3'd0,
		K_LEN   = 3'd1,
		K_TLEN  = 3'd2,
		K_TOPIC = 3'd3,
		K_ID    = 3'd4,
		K_PAY   = 3'd5,
		K_IGN   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_NOTPUB = 3'd2,
		ST_BADLEN = 3'd3,
		ST_TOPIC  = 3'd4,
		ST_IDOVR  = 3'd5,
		ST_TRUNC  = 3'd6
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bytes_seen;
		logic [1:0]  len_cnt;
		logic [27:0] bytes_left;
		logic [15:0] topic_len;
		logic [15:0] topic_left;
		logic [15:0] id;
		logic [3:0]  flags;
		status_t     status;
		logic [27:0] payload_count;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic        done;
		status_t     status;
		logic        dup;
		logic [1:0]  qos;
		logic        retain;
		logic [15:0] message_id;
		logic [15:0] topic_length;
		logic [27:0] payload_length;
	} res_t;

	// parser state at reset and at the start of each buffer
	function automatic state_t idle_state();
		state_t s;
		s        = '0;
		s.phase  = PH_HDR;
		s.status = ST_OK;
		return s;
	endfunction

endpackage

### hdl/mqpp_step.sv
// Per-beat parse step: next parser state and tagged result for one byte.
module mqpp_step
	import mqpp_pkg::*;
(
	input  state_t      cur,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [15:0] max_topic_len,
	output state_t      nxt,
	output res_t        res
);

	function automatic state_t enter_payload(state_t s);
		state_t r;
		r = s;
		r.payload_count = s.bytes_left;
		r.phase = (s.bytes_left != '0) ? PH_PAY : PH_DONE;
		return r;
	endfunction

	function automatic state_t after_topic(state_t s);
		state_t r;
		r = s;
		if (s.flags[2:1] != 2'd0) begin
			if (s.bytes_left < 28'd2) begin
				r.status = ST_IDOVR;
				r.phase  = PH_ERR;
			end else begin
				r.phase = PH_IDH;
			end
		end else begin
			r = enter_payload(s);
		end
		return r;
	endfunction

	state_t      upd;
	kind_t       kind;
	logic [27:0] bl_dec;
	logic [27:0] grp;
	logic [27:0] new_bl;
	logic [15:0] tl;
	status_t     st;

	assign bl_dec = cur.bytes_left - 28'd1;
	assign tl     = {cur.topic_len[15:8], data_byte};
	assign new_bl = cur.bytes_left | grp;

	// 7-bit groups land least significant first
	always_comb begin
		case (cur.len_cnt)
			2'd0:    grp = {21'd0, data_byte[6:0]};
			2'd1:    grp = {14'd0, data_byte[6:0], 7'd0};
			2'd2:    grp = {7'd0, data_byte[6:0], 14'd0};
			default: grp = {data_byte[6:0], 21'd0};
		endcase
	end

	always_comb begin
		upd  = cur;
		kind = K_IGN;
		unique case (cur.phase)
			PH_HDR: begin
				kind = K_HDR;
				upd.flags = data_byte[3:0];
				if (data_byte[7:4] != 4'd3) begin
					upd.status = ST_NOTPUB;
					upd.phase  = PH_ERR;
				end else begin
					upd.phase = PH_LEN;
				end
			end
			PH_LEN: begin
				kind = K_LEN;
				upd.bytes_left = new_bl;
				if (data_byte[7]) begin
					if (cur.len_cnt == 2'(MaxLenBytes - 1)) begin
						upd.status = ST_BADLEN;
						upd.phase  = PH_ERR;
					end else begin
						upd.len_cnt = cur.len_cnt + 2'd1;
					end
				end else if (new_bl < 28'd2) begin
					upd.status = ST_TOPIC;
					upd.phase  = PH_ERR;
				end else begin
					upd.phase = PH_TLH;
				end
			end
			PH_TLH: begin
				kind = K_TLEN;
				upd.topic_len  = {data_byte, 8'd0};
				upd.bytes_left = bl_dec;
				upd.phase      = PH_TLL;
			end
			PH_TLL: begin
				kind = K_TLEN;
				upd.topic_len  = tl;
				upd.bytes_left = bl_dec;
				if (tl > max_topic_len || 28'(tl) > bl_dec) begin
					upd.status = ST_TOPIC;
					upd.phase  = PH_ERR;
				end else begin
					upd.topic_left = tl;
					upd.bytes_left = bl_dec - 28'(tl);
					if (tl == 16'd0)
						upd = after_topic(upd);
					else
						upd.phase = PH_TOPIC;
				end
			end
			PH_TOPIC: begin
				kind = K_TOPIC;
				upd.topic_left = cur.topic_left - 16'd1;
				if (upd.topic_left == 16'd0)
					upd = after_topic(upd);
			end
			PH_IDH: begin
				kind = K_ID;
				upd.id         = {data_byte, 8'd0};
				upd.bytes_left = bl_dec;
				upd.phase      = PH_IDL;
			end
			PH_IDL: begin
				kind = K_ID;
				upd.id         = {cur.id[15:8], data_byte};
				upd.bytes_left = bl_dec;
				upd = enter_payload(upd);
			end
			PH_PAY: begin
				kind = K_PAY;
				upd.bytes_left = bl_dec;
				if (bl_dec == 28'd0)
					upd.phase = PH_DONE;
			end
			default: kind = K_IGN;
		endcase
		if (cur.bytes_seen < 3'd4)
			upd.bytes_seen = cur.bytes_seen + 3'd1;
	end

	assign st = (upd.status == ST_OK && upd.phase != PH_DONE) ? ST_TRUNC : upd.status;

	always_comb begin
		res            = '0;
		res.kind       = kind;
		res.byte_value = data_byte;
		if (last_byte) begin
			res.done = 1'b1;
			if (upd.bytes_seen < 3'd4) begin
				res.status = ST_SHORT;
			end else begin
				res.status         = st;
				res.dup            = upd.flags[3];
				res.qos            = upd.flags[2:1];
				res.retain         = upd.flags[0];
				res.message_id     = upd.id;
				res.topic_length   = upd.topic_len;
				res.payload_length = upd.payload_count;
			end
		end
	end

	// buffer end: start over for the next buffer
	always_comb begin
		if (last_byte) begin
			nxt       = '0;
			nxt.phase = PH_HDR;
		end else begin
			nxt = upd;
		end
	end

endmodule

### hdl/mqtt_publish_parser.sv
// Top level of the MQTT 3.1.1 PUBLISH packet parser.
// Takes one buffer byte per beat and returns one tagged result per byte, with
// the packet summary on the byte marked last_byte; the parser then restarts.
// Sustained rate is one byte per cycle while res_stall is low. A byte is registered
// on input, then parsed by combinational state logic as it moves to the result
// register that drives res_valid. max_topic_len resets to 1024.
module mqtt_publish_parser
	import mqpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_topic_len_we,
	input  logic [15:0] max_topic_len_wdata,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  byte_kind,
	output logic [7:0]  byte_value,
	output logic        done_res,
	output logic [2:0]  status,
	output logic        dup_flag,
	output logic [1:0]  qos_level,
	output logic        retain_flag,
	output logic [15:0] message_id,
	output logic [15:0] topic_length,
	output logic [27:0] payload_length
);

	logic        max_len_q;
	logic [15:0] max_topic_len_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	res_t        res_s2;
	state_t      st_q;
	state_t      st_nxt;
	res_t        res_nxt;
	logic        adv;

	assign max_len_q = max_topic_len_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_topic_len_q <= 16'd1024;
		end else if (max_len_q) begin
			max_topic_len_q <= max_topic_len_wdata;
		end
	end

	// beat in stage 1 moves on whenever the result slot is free or draining
	assign adv        = valid_s1 && (!valid_s2 || !res_stall);
	assign byte_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	mqpp_step u_step (
		.cur           (st_q),
		.data_byte     (byte_s1),
		.last_byte     (last_s1),
		.max_topic_len (max_topic_len_q),
		.nxt           (st_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= idle_state();
			valid_s2 <= 1'b0;
		end else begin
			if (adv)
				st_q <= st_nxt;
			if (adv)
				valid_s2 <= 1'b1;
			else if (!res_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign res_valid      = valid_s2;
	assign byte_kind      = res_s2.kind;
	assign byte_value     = res_s2.byte_value;
	assign done_res       = res_s2.done;
	assign status         = res_s2.status;
	assign dup_flag       = res_s2.dup;
	assign qos_level      = res_s2.qos;
	assign retain_flag    = res_s2.retain;
	assign message_id     = res_s2.message_id;
	assign topic_length   = res_s2.topic_length;
	assign payload_length = res_s2.payload_length;

`ifndef ASSERT_OFF
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (st_q.phase == PH_HDR && st_q.bytes_seen == 3'd0))
		else $error("parser did not restart after last beat");

	a_no_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.done) |->
		(res_s2.status == ST_OK && res_s2.payload_length == 28'd0 &&
		 res_s2.message_id == 16'd0))
		else $error("summary fields set on a non-final beat");

	a_short_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status == ST_SHORT) |->
		(res_s2.topic_length == 16'd0 && res_s2.qos == 2'd0))
		else $error("short buffer reported header fields");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && valid_s2 && res_stall))
		else $error("input stalled without a blocked result");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced beat lost from result stage");
`endif

endmodule

### tb/tb_mqtt_publish_parser.sv
// Self-checking testbench for the MQTT PUBLISH packet parser, with byte-level predictor.
module tb_mqtt_publish_parser;
	import mqpp_pkg::*;

	localparam int StuckLimit = 4000;
	localparam int BytesPerPhase = 300;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic       pin;
		kind_t      kind;
		status_t    st;
	} dir_row_t;

	// pinned rows carry the tag and status typed in; the rest come from the predictor
	localparam dir_row_t DirRows [30] = '{
		'{8'h30, 1'b1, 1'b1, K_HDR,   ST_SHORT},
		'{8'hFF, 1'b0, 1'b1, K_HDR,   ST_OK},
		'{8'h00, 1'b0, 1'b1, K_IGN,   ST_OK},
		'{8'h00, 1'b0, 1'b1, K_IGN,   ST_OK},
		'{8'h00, 1'b1, 1'b1, K_IGN,   ST_NOTPUB},
		'{8'h30, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'hFF, 1'b0, 1'b1, K_LEN,   ST_OK},
		'{8'hFF, 1'b0, 1'b1, K_LEN,   ST_OK},
		'{8'hFF, 1'b0, 1'b1, K_LEN,   ST_OK},
		'{8'hFF, 1'b1, 1'b1, K_LEN,   ST_BADLEN},
		'{8'h31, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h01, 1'b0, 1'b1, K_LEN,   ST_OK},
		'{8'h00, 1'b0, 1'b1, K_IGN,   ST_OK},
		'{8'h00, 1'b1, 1'b1, K_IGN,   ST_TOPIC},
		'{8'h37, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h03, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h00, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h01, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h78, 1'b1, 1'b1, K_TOPIC, ST_IDOVR},
		'{8'h3A, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h04, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h00, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h00, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h12, 1'b0, 1'b1, K_ID,    ST_OK},
		'{8'h34, 1'b0, 1'b1, K_ID,    ST_OK},
		'{8'h99, 1'b1, 1'b1, K_IGN,   ST_OK},
		'{8'h30, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h7F, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h00, 1'b0, 1'b0, K_HDR,   ST_OK},
		'{8'h00, 1'b1, 1'b1, K_TLEN,  ST_TRUNC}
	};

	localparam logic [15:0] TopicCaps [6] = '{16'hFFFF, 16'd0, 16'd3, 16'd1024, 16'd0, 16'd5};

	logic        clk;
	logic        arst_n;
	logic        max_topic_len_we;
	logic [15:0] max_topic_len_wdata;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        res_valid;
	logic        res_stall;
	logic [2:0]  byte_kind;
	logic [7:0]  byte_value;
	logic        done_res;
	logic [2:0]  status;
	logic        dup_flag;
	logic [1:0]  qos_level;
	logic        retain_flag;
	logic [15:0] message_id;
	logic [15:0] topic_length;
	logic [27:0] payload_length;

	// parser shadow state
	phase_t      parse_ph;
	logic [2:0]  seen_cnt;
	logic [1:0]  varint_idx;
	logic [27:0] pkt_left;
	logic [15:0] topic_len_seen;
	logic [15:0] topic_rem;
	logic [15:0] pkt_id_seen;
	logic [3:0]  hdr_flags;
	status_t     first_err;
	logic [27:0] payload_decl;
	logic [15:0] topic_cap;

	res_t        expected_q [$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          buffers_done = 0;
	int          status_seen [7] = '{default: 0};
	int unsigned tx_pct = 8;
	int unsigned rx_pct = 85;
	int          tx_quiet = 0;
	int          rx_quiet = 0;

	mqtt_publish_parser dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.max_topic_len_we    (max_topic_len_we),
		.max_topic_len_wdata (max_topic_len_wdata),
		.byte_valid          (byte_valid),
		.byte_stall          (byte_stall),
		.data_byte           (data_byte),
		.last_byte           (last_byte),
		.res_valid           (res_valid),
		.res_stall           (res_stall),
		.byte_kind           (byte_kind),
		.byte_value          (byte_value),
		.done_res            (done_res),
		.status              (status),
		.dup_flag            (dup_flag),
		.qos_level           (qos_level),
		.retain_flag         (retain_flag),
		.message_id          (message_id),
		.topic_length        (topic_length),
		.payload_length      (payload_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_parser();
		parse_ph       = PH_HDR;
		seen_cnt       = '0;
		varint_idx     = '0;
		pkt_left       = '0;
		topic_len_seen = '0;
		topic_rem      = '0;
		pkt_id_seen    = '0;
		hdr_flags      = '0;
		first_err      = ST_OK;
		payload_decl   = '0;
	endfunction

	function automatic void reject(input status_t code);
		first_err = code;
		parse_ph  = PH_ERR;
	endfunction

	function automatic void start_payload();
		payload_decl = pkt_left;
		parse_ph     = (pkt_left != 28'd0) ? PH_PAY : PH_DONE;
	endfunction

	// nonzero QoS needs two bytes of packet id room after the topic
	function automatic void finish_topic();
		if (hdr_flags[2:1] != 2'b00) begin
			if (pkt_left < 28'd2)
				reject(ST_IDOVR);
			else
				parse_ph = PH_IDH;
		end else begin
			start_payload();
		end
	endfunction

	function automatic res_t parse_byte(input logic [7:0] b, input logic lst);
		res_t    r;
		kind_t   k;
		status_t st;
		k = K_IGN;
		case (parse_ph)
			PH_HDR: begin
				k = K_HDR;
				hdr_flags = b[3:0];
				if (b[7:4] != 4'h3)
					reject(ST_NOTPUB);
				else
					parse_ph = PH_LEN;
			end
			PH_LEN: begin
				k = K_LEN;
				pkt_left = pkt_left | (28'(b[6:0]) << (7 * varint_idx));
				if (b[7]) begin
					if (varint_idx >= 2'(MaxLenBytes - 1))
						reject(ST_BADLEN);
					else
						varint_idx = varint_idx + 2'd1;
				end else if (pkt_left < 28'd2) begin
					reject(ST_TOPIC);
				end else begin
					parse_ph = PH_TLH;
				end
			end
			PH_TLH: begin
				k = K_TLEN;
				topic_len_seen = {b, 8'h00};
				pkt_left = pkt_left - 28'd1;
				parse_ph = PH_TLL;
			end
			PH_TLL: begin
				k = K_TLEN;
				topic_len_seen[7:0] = b;
				pkt_left = pkt_left - 28'd1;
				if (topic_len_seen > topic_cap || 28'(topic_len_seen) > pkt_left) begin
					reject(ST_TOPIC);
				end else begin
					topic_rem = topic_len_seen;
					pkt_left = pkt_left - 28'(topic_len_seen);
					if (topic_rem == 16'd0)
						finish_topic();
					else
						parse_ph = PH_TOPIC;
				end
			end
			PH_TOPIC: begin
				k = K_TOPIC;
				topic_rem = topic_rem - 16'd1;
				if (topic_rem == 16'd0)
					finish_topic();
			end
			PH_IDH: begin
				k = K_ID;
				pkt_id_seen = {b, 8'h00};
				pkt_left = pkt_left - 28'd1;
				parse_ph = PH_IDL;
			end
			PH_IDL: begin
				k = K_ID;
				pkt_id_seen[7:0] = b;
				pkt_left = pkt_left - 28'd1;
				start_payload();
			end
			PH_PAY: begin
				k = K_PAY;
				pkt_left = pkt_left - 28'd1;
				if (pkt_left == 28'd0)
					parse_ph = PH_DONE;
			end
			default: k = K_IGN;
		endcase
		if (seen_cnt < 3'd4)
			seen_cnt = seen_cnt + 3'd1;

		r = '0;
		r.kind = k;
		r.byte_value = b;
		if (lst) begin
			r.done = 1'b1;
			if (seen_cnt < 3'd4) begin
				r.status = ST_SHORT;
			end else begin
				st = first_err;
				if (st == ST_OK && parse_ph != PH_DONE)
					st = ST_TRUNC;
				r.status = st;
				r.dup = hdr_flags[3];
				r.qos = hdr_flags[2:1];
				r.retain = hdr_flags[0];
				r.message_id = pkt_id_seen;
				r.topic_length = topic_len_seen;
				r.payload_length = payload_decl;
			end
			clear_parser();
		end
		return r;
	endfunction

	function automatic void note_field(input string name, input logic [27:0] want,
			input logic [27:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic put_byte(input logic [7:0] b, input logic lst, input logic pin,
			input kind_t k, input status_t st);
		res_t want;
		if (tx_quiet > 0) begin
			tx_quiet--;
		end else begin
			if ($urandom_range(149) == 0)
				tx_quiet = $urandom_range(15, 60);
			while ($urandom_range(99) < tx_pct) begin
				byte_valid <= 1'b0;
				@(negedge clk);
			end
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= lst;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		want = parse_byte(b, lst);
		if (pin) begin
			want.kind = k;
			want.status = st;
		end
		expected_q.push_back(want);
		bytes_sent++;
		@(negedge clk);
	endtask

	initial begin : rx_idle
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_quiet > 0) begin
				rx_quiet--;
				res_stall <= 1'b0;
			end else begin
				if ($urandom_range(149) == 0)
					rx_quiet = $urandom_range(15, 60);
				res_stall <= ($urandom_range(99) < rx_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got kind %0d value %0h",
					$time, byte_kind, byte_value);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				note_field("byte_kind", want.kind, byte_kind);
				note_field("byte_value", want.byte_value, byte_value);
				note_field("done_res", want.done, done_res);
				note_field("status", want.status, status);
				note_field("dup_flag", want.dup, dup_flag);
				note_field("qos_level", want.qos, qos_level);
				note_field("retain_flag", want.retain, retain_flag);
				note_field("message_id", want.message_id, message_id);
				note_field("topic_length", want.topic_length, topic_length);
				note_field("payload_length", want.payload_length, payload_length);
				if (want.done) begin
					buffers_done++;
					status_seen[want.status]++;
				end
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < StuckLimit) begin
			@(posedge clk);
			if (!arst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, StuckLimit);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  q [$];
		logic [7:0]  hdr;
		logic [27:0] rl;
		logic [15:0] tl;
		int          phase_start;
		int unsigned mode, nid, pay, nmin, nlen, n_topic, n_pay, cut, vstyle, keep;

		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		max_topic_len_we = 1'b0;
		max_topic_len_wdata = 16'h0000;
		topic_cap = 16'd1024;
		clear_parser();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed buffers at the reset topic limit
		foreach (DirRows[i])
			put_byte(DirRows[i].b, DirRows[i].lst, DirRows[i].pin, DirRows[i].kind,
				DirRows[i].st);

		for (int p = 0; p < 6; p++) begin
			// drain before touching the limit register
			byte_valid <= 1'b0;
			while (expected_q.size() != 0)
				@(negedge clk);
			topic_cap = (p == 4) ? 16'($urandom) : TopicCaps[p];
			max_topic_len_we <= 1'b1;
			max_topic_len_wdata <= topic_cap;
			@(negedge clk);
			max_topic_len_we <= 1'b0;

			case (p / 2)
				0: begin
					tx_pct = 8;
					rx_pct = 85;
				end
				1: begin
					tx_pct = 85;
					rx_pct = 8;
				end
				default: begin
					tx_pct = 0;
					rx_pct = 0;
				end
			endcase

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < BytesPerPhase) begin
				q.delete();
				mode = $urandom_range(99);
				hdr = {4'h3, 4'($urandom)};
				if (mode >= 92) begin
					// raw noise, often shorter than a header
					repeat ($urandom_range(1, 8))
						q.push_back(8'($urandom));
				end else begin
					if (mode >= 84) begin
						while (hdr[7:4] == 4'h3)
							hdr[7:4] = 4'($urandom);
					end
					tl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
					nid = (hdr[2:1] != 2'b00) ? 2 : 0;
					pay = $urandom_range(0, 12);
					rl = 28'(2 + tl + nid + pay);
					n_pay = pay;
					if (mode >= 76 && mode < 84) begin
						// huge declared length, buffer ends long before the packet does
						rl = ($urandom_range(3) == 0) ? 28'hFFFFFFF : 28'($urandom);
						n_pay = $urandom_range(0, 20);
					end else if (mode >= 64 && mode < 76) begin
						rl = 28'($urandom_range(0, 32'(rl) - 1));
					end
					q.push_back(hdr);

					vstyle = $urandom_range(19);
					if (vstyle == 0) begin
						// continuation bit still set on the fourth length beat
						repeat (4)
							q.push_back({1'b1, 7'($urandom)});
					end else begin
						nmin = 1;
						while (nmin < 4 && (rl >> (7 * nmin)) != 28'd0)
							nmin++;
						nlen = (vstyle <= 2) ? $urandom_range(nmin, 4) : nmin;
						for (int i = 0; i < nlen; i++)
							q.push_back({1'(i + 1 < nlen), 7'(rl >> (7 * i))});
					end

					q.push_back(tl[15:8]);
					q.push_back(tl[7:0]);
					n_topic = (tl > 16'd12) ? $urandom_range(0, 12) : tl;
					repeat (n_topic)
						q.push_back(8'($urandom));
					repeat (nid)
						q.push_back(8'($urandom));
					repeat (n_pay)
						q.push_back(8'($urandom));
				end

				cut = $urandom_range(99);
				if (cut < 12 && q.size() > 1) begin
					keep = $urandom_range(1, q.size() - 1);
					while (q.size() > keep)
						void'(q.pop_back());
				end else if (cut < 30) begin
					repeat ($urandom_range(1, 4))
						q.push_back(8'($urandom));
				end

				foreach (q[i])
					put_byte(q[i], 1'(i == q.size() - 1), 1'b0, K_IGN, ST_OK);
			end
		end

		byte_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d bytes in %0d buffers, topic limits from 0 to 65535, idling on each side",
			bytes_sent, buffers_done);
		$display("status mix: ok %0d short %0d not-publish %0d bad-length %0d topic %0d id %0d trunc %0d",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_NOTPUB],
			status_seen[ST_BADLEN], status_seen[ST_TOPIC], status_seen[ST_IDOVR],
			status_seen[ST_TRUNC]);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
